### rtl/fault_event_recorder_core_assert.svh
// Assertion macros for the fault event recorder.
// Needs a signal named clock and a signal named reset in the including scope.
`ifndef FAULT_EVENT_RECORDER_CORE_ASSERT_SVH
`define FAULT_EVENT_RECORDER_CORE_ASSERT_SVH

// same-cycle implication
`define FER_ASSERT_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("fault event recorder: same-cycle check failed");

// next-cycle implication
`define FER_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("fault event recorder: next-cycle check failed");

`endif

### rtl/fer_pkg.sv
// Shared types and codes for the fault event recorder.
// No dependencies.
package fer_pkg;

   typedef logic [1:0] status_type;
   typedef logic [1:0] led_type;
   typedef logic [7:0] record_type;
   typedef logic [15:0] events_type;

   localparam status_type ST_NORMAL  = 2'd0;
   localparam status_type ST_FAULT   = 2'd1;
   localparam status_type ST_WARNING = 2'd2;

   localparam led_type LED_OFF   = 2'd0;
   localparam led_type LED_BLINK = 2'd1;
   localparam led_type LED_ON    = 2'd2;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_CYCLE_MARKER = 3'd0;

endpackage

### rtl/fer_req_if.sv
// Request channel carrying one evaluation beat of three statuses.
// Depends on fer_pkg.
interface fer_req_if;
   import fer_pkg::*;

   logic       valid;
   logic       ready;
   status_type comm_status;
   status_type data_status;
   status_type env_status;

   modport source (output valid, output comm_status, output data_status,
                   output env_status, input ready);
   modport sink (input valid, input comm_status, input data_status,
                 input env_status, output ready);
endinterface

### rtl/fer_rsp_if.sv
// Response channel carrying one result beat.
// Depends on fer_pkg.
interface fer_rsp_if;
   import fer_pkg::*;

   logic       valid;
   logic       ready;
   led_type    led_mode;
   logic       data_stale;
   logic       store_request;
   record_type comm_record;
   record_type data_record;
   record_type env_record;
   events_type comm_events;
   events_type data_events;
   events_type env_events;

   modport source (output valid, output led_mode, output data_stale,
                   output store_request, output comm_record, output data_record,
                   output env_record, output comm_events, output data_events,
                   output env_events, input ready);
   modport sink (input valid, input led_mode, input data_stale,
                 input store_request, input comm_record, input data_record,
                 input env_record, input comm_events, input data_events,
                 input env_events, output ready);
endinterface

### rtl/fer_csr.sv
// APB-style register block holding the cycle marker.
// Depends on fer_pkg.
module fer_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fer_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [fer_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [fer_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output fer_pkg::record_type                  marker
);
   import fer_pkg::*;

   record_type marker_ff;
   record_type marker_in;
   logic       write_hit;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == ADDR_CYCLE_MARKER);
   assign marker_in  = write_hit ? csr_pwdata[7:0] : marker_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= '0;
      end else begin
         marker_ff <= marker_in;
      end
   end

   assign csr_prdata = (csr_paddr == ADDR_CYCLE_MARKER)
                       ? CSR_DATA_WIDTH'(marker_ff) : '0;
   assign marker     = marker_ff;
endmodule

### rtl/fer_channel.sv
// One diagnostic channel: transition detect, wrapping counter, first record.
// Depends on fer_pkg.
module fer_channel #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  fer_pkg::status_type       status_now,
   input  fer_pkg::status_type       target,
   input  fer_pkg::record_type       marker,
   output logic                      hit,
   output fer_pkg::record_type       record,
   output logic [COUNT_WIDTH-1:0]    count
);
   import fer_pkg::*;

   status_type             last_ff, last_in;
   logic                   captured_ff, captured_in;
   record_type             rec_ff, rec_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   assign hit = advance && (status_now == target) && (last_ff == ST_NORMAL);

   always_comb begin
      last_in     = advance ? status_now : last_ff;
      captured_in = captured_ff || hit;
      rec_in      = (hit && !captured_ff) ? (marker | record_type'(status_now)) : rec_ff;
      count_in    = hit ? count_ff + COUNT_WIDTH'(1) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff     <= ST_NORMAL;
         captured_ff <= 1'b0;
         rec_ff      <= '0;
         count_ff    <= '0;
      end else begin
         last_ff     <= last_in;
         captured_ff <= captured_in;
         rec_ff      <= rec_in;
         count_ff    <= count_in;
      end
   end

   assign record = rec_ff;
   assign count  = count_ff;
endmodule

### rtl/fault_event_recorder_core.sv
// Fault event recorder top level: input register, three channel trackers, result register.
// A request beat passes the input register and then the result register to become a response
// beat; one beat per cycle sustained while rsp_chan.ready is high.
// Synchronous active-high reset empties both registers and clears marker, previous
// statuses, capture flags, records and counters.
// Depends on fer_pkg, fer_req_if, fer_rsp_if, fer_csr, fer_channel.
`include "fault_event_recorder_core_assert.svh"
module fault_event_recorder_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   fer_req_if.sink                              req_chan,
   fer_rsp_if.source                            rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fer_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [fer_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [fer_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import fer_pkg::*;

   record_type             marker;
   logic                   in_valid_ff, in_valid_in;
   status_type             comm_ff, data_ff, env_ff;
   status_type             comm_in, data_in, env_in;
   logic                   out_valid_ff, out_valid_in;
   led_type                led_ff, led_in;
   logic                   stale_ff, stale_in;
   logic                   store_ff, store_in;
   logic                   advance;
   logic                   take;
   logic                   comm_hit, data_hit, env_hit;
   record_type             comm_rec, data_rec, env_rec;
   logic [COUNT_WIDTH-1:0] comm_cnt, data_cnt, env_cnt;

   fer_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .marker      (marker)
   );

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   fer_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_comm (
      .clock (clock), .reset (reset), .advance (advance),
      .status_now (comm_ff), .target (ST_FAULT), .marker (marker),
      .hit (comm_hit), .record (comm_rec), .count (comm_cnt)
   );

   fer_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_data (
      .clock (clock), .reset (reset), .advance (advance),
      .status_now (data_ff), .target (ST_FAULT), .marker (marker),
      .hit (data_hit), .record (data_rec), .count (data_cnt)
   );

   fer_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_env (
      .clock (clock), .reset (reset), .advance (advance),
      .status_now (env_ff), .target (ST_WARNING), .marker (marker),
      .hit (env_hit), .record (env_rec), .count (env_cnt)
   );

   always_comb begin
      in_valid_in  = take || (in_valid_ff && !advance);
      comm_in      = take ? req_chan.comm_status : comm_ff;
      data_in      = take ? req_chan.data_status : data_ff;
      env_in       = take ? req_chan.env_status : env_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

      priority if ((comm_ff == ST_FAULT) || (data_ff == ST_FAULT)) begin
         led_in = LED_OFF;
      end else if (env_ff == ST_WARNING) begin
         led_in = LED_BLINK;
      end else begin
         led_in = LED_ON;
      end
      stale_in = (comm_ff != ST_NORMAL) || (data_ff != ST_NORMAL) || (env_ff != ST_NORMAL);
      store_in = comm_hit || data_hit || env_hit;
      if (!advance) begin
         led_in   = led_ff;
         stale_in = stale_ff;
         store_in = store_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      comm_ff  <= comm_in;
      data_ff  <= data_in;
      env_ff   <= env_in;
      led_ff   <= led_in;
      stale_ff <= stale_in;
      store_ff <= store_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.led_mode      = led_ff;
   assign rsp_chan.data_stale    = stale_ff;
   assign rsp_chan.store_request = store_ff;
   assign rsp_chan.comm_record   = comm_rec;
   assign rsp_chan.data_record   = data_rec;
   assign rsp_chan.env_record    = env_rec;
   assign rsp_chan.comm_events   = events_type'(comm_cnt);
   assign rsp_chan.data_events   = events_type'(data_cnt);
   assign rsp_chan.env_events    = events_type'(env_cnt);

   `FER_ASSERT_NOW(a_store_implies_stale, out_valid_ff && store_ff, stale_ff)
   `FER_ASSERT_NOW(a_clean_implies_on, out_valid_ff && !stale_ff, led_ff == LED_ON)
   `FER_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_ff)
   `FER_ASSERT_NEXT(a_counts_hold_when_idle, !advance,
                    $stable(comm_cnt) && $stable(data_cnt) && $stable(env_cnt))

endmodule
